/* hdl/csp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types, codes and helpers of the cubature sigma point generator.
// ----------------------------------------------------------------------------
package csp_pkg;

    localparam int DATA_W    = 32;
    localparam int ACC_W     = 64;
    localparam int MUL_W     = 34;
    localparam int PROD_W    = 68;
    localparam int PN_W      = 6;
    localparam int IDX_W     = 3;
    localparam int FADDR_W   = 5;
    localparam int NUM_COORD = 5;

    typedef enum logic [1:0] {
        OP_LOAD_MEAN = 2'd0,
        OP_LOAD_COV  = 2'd1,
        OP_GENERATE  = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_RD,
        ST_LD_ACC,
        ST_MAC_RD,
        ST_MAC_MUL,
        ST_MAC_ACC,
        ST_DCHK,
        ST_ZERO,
        ST_SQRT,
        ST_DIV_GO,
        ST_DIV,
        ST_COORD,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_DIAG,
        PH_OFF,
        PH_EMIT
    } phase_t;

    typedef enum logic [1:0] {
        EP_MEAN,
        EP_PAT,
        EP_AXIS
    } point_kind_t;

    typedef enum logic [1:0] {
        MS_NONE,
        MS_HALF,
        MS_BETA
    } mult_sel_t;

    typedef enum logic [1:0] {
        FW_ROOT,
        FW_QUOT,
        FW_ZERO
    } fw_sel_t;

    typedef struct packed {
        logic [FADDR_W-1:0] fa_addr;
        logic [FADDR_W-1:0] fb_addr;
        logic [FADDR_W-1:0] cov_addr;
        logic [FADDR_W-1:0] fw_addr;
        logic [IDX_W-1:0]   mean_addr;
        logic [IDX_W-1:0]   coord_idx;
        logic               acc_load;
        logic               acc_from_mean;
        logic               mul_en;
        logic               emit_mode;
        logic               acc_upd;
        logic               mask_a;
        logic               mask_b;
        logic               neg_a;
        logic               neg_b;
        logic               use_b;
        mult_sel_t          mult_sel;
        logic               sqrt_start;
        logic               div_start;
        logic               fw_en;
        fw_sel_t            fw_sel;
        logic               bad_clr;
        logic               bad_set;
        logic               coord_wr;
        logic               out_load;
        logic [PN_W-1:0]    point_num;
        logic               last;
    } cmd_t;

    typedef struct packed {
        logic acc_le_zero;
        logic sqrt_done;
        logic div_done;
        logic out_free;
    } stat_t;

    function automatic logic [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [DATA_W-1:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'h8000_0000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // floor square root, two radicand bits per step
    function automatic logic [63:0] isqrt_const(input logic [63:0] x);
        logic [63:0] xs;
        logic [35:0] rem;
        logic [35:0] trial;
        logic [31:0] root;
        xs   = x;
        rem  = '0;
        root = '0;
        for (int n = 0; n < 32; n++) begin
            rem   = {rem[33:0], xs[63:62]};
            xs    = xs << 2;
            trial = {2'b00, root, 2'b01};
            if (rem >= trial) begin
                rem  = rem - trial;
                root = {root[30:0], 1'b1};
            end else begin
                root = {root[30:0], 1'b0};
            end
        end
        return {32'd0, root};
    endfunction

endpackage
`default_nettype wire

/* hdl/cubature_sigma_point_generator.sv */
`default_nettype none
// Load items are accepted back to back while the block is idle.
// A generate item holds s_tready low until its last point is handed to the output
// register: each positive diagonal goes through the iterative square root and each lower
// entry of its column through the 64-step divider, and then the points are formed.
// Reset clears the sequencer and the output valid; the stores hold no value until written.
// ----------------------------------------------------------------------------
// cubature_sigma_point_generator
// Fifth-degree cubature point generator with Cholesky factorization.
// ----------------------------------------------------------------------------
module cubature_sigma_point_generator #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [39:0]  s_tdata,  // row_index, col_index, value
    input  wire logic [1:0]   s_tuser,  // op
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [167:0]      m_tdata,  // point_number, coord_zero .. coord_four
    output logic              m_tlast,  // last_point
    output logic              m_tuser   // not_positive_definite
);

    csp_pkg::cmd_t  cmd;
    csp_pkg::stat_t stat;
    logic           idle;
    logic           s_acc;
    logic [csp_pkg::PN_W-1:0] out_point;
    logic [31:0]    out_coord [csp_pkg::NUM_COORD];

    assign s_tready = idle;
    assign s_acc    = s_tvalid && idle;

    csp_ctrl #(
        .DIM (DIM)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (s_acc && s_tuser == csp_pkg::OP_GENERATE),
        .stat    (stat),
        .cmd     (cmd),
        .idle    (idle)
    );

    csp_datapath #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_en    (s_acc),
        .load_op    (s_tuser),
        .load_row   (s_tdata[2:0]),
        .load_col   (s_tdata[5:3]),
        .load_value (s_tdata[37:6]),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_point  (out_point),
        .out_coord  (out_coord),
        .out_last   (m_tlast),
        .out_bad    (m_tuser)
    );

    assign m_tdata = {2'b00, out_coord[4], out_coord[3], out_coord[2],
                      out_coord[1], out_coord[0], out_point};

endmodule
`default_nettype wire

/* hdl/csp_isqrt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csp_isqrt
// Iterative floor square root of a 64-bit radicand, one root bit per cycle.
// ----------------------------------------------------------------------------
module csp_isqrt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] rad,
    output logic             done,
    output logic [31:0]      root
);

    logic [63:0] x_reg, x_next;
    logic [35:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [35:0] rem_sh;
    logic [35:0] trial;

    always_comb begin
        rem_sh    = {rem_reg[33:0], x_reg[63:62]};
        trial     = {2'b00, root_reg, 2'b01};
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            x_next    = rad;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            x_next   = x_reg << 2;
            cnt_next = cnt_reg + 5'd1;
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[30:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[30:0], 1'b0};
            end
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

/* hdl/csp_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csp_div
// Restoring unsigned divider, 64-bit dividend by 32-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module csp_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [63:0]      quot
);

    logic [63:0] q_reg, q_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] rem_sh;

    always_comb begin
        rem_sh    = {rem_reg[31:0], q_reg[63]};
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 6'd1;
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                q_next   = {q_reg[62:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                q_next   = {q_reg[62:0], 1'b0};
            end
            if (cnt_reg == 6'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule
`default_nettype wire

/* hdl/csp_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csp_ctrl
// Sequencer for the Cholesky factorization and the point emission.
// ----------------------------------------------------------------------------
module csp_ctrl #(
    parameter int DIM = 4
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           go,
    input  wire csp_pkg::stat_t stat,
    output csp_pkg::cmd_t       cmd,
    output logic                idle
);

    localparam int ROW_W = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int FAW   = csp_pkg::FADDR_W;
    localparam int IW    = csp_pkg::IDX_W;
    localparam int PNW   = csp_pkg::PN_W;
    localparam logic [ROW_W-1:0] DLAST = ROW_W'(DIM - 1);
    localparam logic [ROW_W-1:0] PLAST = ROW_W'((DIM > 1) ? DIM - 2 : 0);
    localparam logic [PNW-1:0]   PN_LAST = PNW'(2 * DIM * DIM);

    csp_pkg::state_t      state_reg, state_next;
    csp_pkg::phase_t      ph_reg, ph_next;
    csp_pkg::point_kind_t ept_reg, ept_next;
    logic [ROW_W-1:0] j_reg, j_next, i_reg, i_next, k_reg, k_next, r_reg, r_next;
    logic [ROW_W-1:0] pi_reg, pi_next, pj_reg, pj_next;
    logic [1:0]       pk_reg, pk_next;
    logic             ak_reg, ak_next;
    logic [PNW-1:0]   pn_reg, pn_next;
    logic             emit;

    function automatic logic [FAW-1:0] fidx(input logic [ROW_W-1:0] row,
                                            input logic [ROW_W-1:0] col);
        return FAW'(row * DIM + col);
    endfunction

    assign emit = (ph_reg == csp_pkg::PH_EMIT);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            csp_pkg::ST_IDLE: begin
                if (go) state_next = csp_pkg::ST_LD_RD;
            end
            csp_pkg::ST_LD_RD:   state_next = csp_pkg::ST_LD_ACC;
            csp_pkg::ST_LD_ACC: begin
                if (emit || j_reg != '0) begin
                    state_next = csp_pkg::ST_MAC_RD;
                end else begin
                    state_next = csp_pkg::ST_DCHK;
                end
            end
            csp_pkg::ST_MAC_RD:  state_next = csp_pkg::ST_MAC_MUL;
            csp_pkg::ST_MAC_MUL: state_next = csp_pkg::ST_MAC_ACC;
            csp_pkg::ST_MAC_ACC: begin
                if (!emit && ROW_W'(k_reg + 1'b1) != j_reg) begin
                    state_next = csp_pkg::ST_MAC_RD;
                end else if (emit) begin
                    state_next = csp_pkg::ST_COORD;
                end else if (ph_reg == csp_pkg::PH_OFF) begin
                    state_next = csp_pkg::ST_DIV_GO;
                end else begin
                    state_next = csp_pkg::ST_DCHK;
                end
            end
            csp_pkg::ST_DCHK: begin
                if (ph_reg == csp_pkg::PH_OFF) begin
                    state_next = csp_pkg::ST_DIV_GO;
                end else if (stat.acc_le_zero) begin
                    state_next = csp_pkg::ST_ZERO;
                end else begin
                    state_next = csp_pkg::ST_SQRT;
                end
            end
            csp_pkg::ST_ZERO: begin
                if (i_reg == DLAST) state_next = csp_pkg::ST_LD_RD;
            end
            csp_pkg::ST_SQRT: begin
                if (stat.sqrt_done) state_next = csp_pkg::ST_LD_RD;
            end
            csp_pkg::ST_DIV_GO:  state_next = csp_pkg::ST_DIV;
            csp_pkg::ST_DIV: begin
                if (stat.div_done) state_next = csp_pkg::ST_LD_RD;
            end
            csp_pkg::ST_COORD: begin
                if (r_reg == DLAST) begin
                    state_next = csp_pkg::ST_OUT;
                end else begin
                    state_next = csp_pkg::ST_LD_RD;
                end
            end
            csp_pkg::ST_OUT: begin
                if (stat.out_free) begin
                    state_next = (pn_reg == PN_LAST) ? csp_pkg::ST_IDLE : csp_pkg::ST_LD_RD;
                end
            end
            default: state_next = csp_pkg::ST_IDLE;
        endcase
    end

    // loop counters
    always_comb begin
        ph_next  = ph_reg;
        ept_next = ept_reg;
        j_next   = j_reg;
        i_next   = i_reg;
        k_next   = k_reg;
        r_next   = r_reg;
        pi_next  = pi_reg;
        pj_next  = pj_reg;
        pk_next  = pk_reg;
        ak_next  = ak_reg;
        pn_next  = pn_reg;
        case (state_reg)
            csp_pkg::ST_IDLE: begin
                ph_next = csp_pkg::PH_DIAG;
                j_next  = '0;
            end
            csp_pkg::ST_LD_ACC: k_next = '0;
            csp_pkg::ST_MAC_ACC: k_next = ROW_W'(k_reg + 1'b1);
            csp_pkg::ST_DCHK: begin
                if (ph_reg == csp_pkg::PH_DIAG) i_next = j_reg;
            end
            csp_pkg::ST_ZERO, csp_pkg::ST_DIV: begin
                if ((state_reg == csp_pkg::ST_ZERO) || stat.div_done) begin
                    if (i_reg != DLAST) begin
                        i_next = ROW_W'(i_reg + 1'b1);
                    end else if (j_reg != DLAST) begin
                        j_next  = ROW_W'(j_reg + 1'b1);
                        ph_next = csp_pkg::PH_DIAG;
                    end else begin
                        ph_next  = csp_pkg::PH_EMIT;
                        ept_next = csp_pkg::EP_MEAN;
                        pn_next  = '0;
                        r_next   = '0;
                    end
                end
            end
            csp_pkg::ST_SQRT: begin
                if (stat.sqrt_done) begin
                    if (j_reg != DLAST) begin
                        i_next  = ROW_W'(j_reg + 1'b1);
                        ph_next = csp_pkg::PH_OFF;
                    end else begin
                        ph_next  = csp_pkg::PH_EMIT;
                        ept_next = csp_pkg::EP_MEAN;
                        pn_next  = '0;
                        r_next   = '0;
                    end
                end
            end
            csp_pkg::ST_COORD: r_next = ROW_W'(r_reg + 1'b1);
            csp_pkg::ST_OUT: begin
                if (stat.out_free) begin
                    r_next  = '0;
                    pn_next = pn_reg + 1'b1;
                    unique case (ept_reg)
                        csp_pkg::EP_MEAN: begin
                            pi_next = '0;
                            ak_next = 1'b0;
                            pk_next = '0;
                            if (DIM > 1) begin
                                ept_next = csp_pkg::EP_PAT;
                                pj_next  = ROW_W'(1);
                            end else begin
                                ept_next = csp_pkg::EP_AXIS;
                            end
                        end
                        csp_pkg::EP_PAT: begin
                            if (pj_reg != DLAST) begin
                                pj_next = ROW_W'(pj_reg + 1'b1);
                            end else if (pi_reg != PLAST) begin
                                pi_next = ROW_W'(pi_reg + 1'b1);
                                pj_next = ROW_W'(pi_reg + 2'd2);
                            end else if (pk_reg != 2'd3) begin
                                pk_next = pk_reg + 2'd1;
                                pi_next = '0;
                                pj_next = ROW_W'(1);
                            end else begin
                                ept_next = csp_pkg::EP_AXIS;
                                ak_next  = 1'b0;
                                pi_next  = '0;
                            end
                        end
                        default: begin
                            if (pi_reg != DLAST) begin
                                pi_next = ROW_W'(pi_reg + 1'b1);
                            end else begin
                                ak_next = 1'b1;
                                pi_next = '0;
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.cov_addr  = (ph_reg == csp_pkg::PH_DIAG) ? fidx(j_reg, j_reg) : fidx(i_reg, j_reg);
        cmd.fa_addr   = emit ? fidx(r_reg, pi_reg)
                      : ((ph_reg == csp_pkg::PH_DIAG) ? fidx(j_reg, k_reg) : fidx(i_reg, k_reg));
        cmd.fb_addr   = emit ? fidx(r_reg, pj_reg) : fidx(j_reg, k_reg);
        cmd.fw_addr   = (state_reg == csp_pkg::ST_SQRT) ? fidx(j_reg, j_reg) : fidx(i_reg, j_reg);
        cmd.mean_addr = IW'(r_reg);
        cmd.coord_idx = IW'(r_reg);
        cmd.acc_from_mean = emit;
        cmd.emit_mode = emit;
        cmd.mask_a    = emit && (r_reg < pi_reg);
        cmd.mask_b    = emit && (r_reg < pj_reg);
        cmd.neg_a     = (ept_reg == csp_pkg::EP_PAT) ? pk_reg[1] : ak_reg;
        cmd.neg_b     = pk_reg[0];
        cmd.use_b     = (ept_reg == csp_pkg::EP_PAT);
        cmd.mult_sel  = (ept_reg == csp_pkg::EP_PAT)  ? csp_pkg::MS_HALF :
                        (ept_reg == csp_pkg::EP_AXIS) ? csp_pkg::MS_BETA : csp_pkg::MS_NONE;
        cmd.fw_sel    = csp_pkg::FW_ZERO;
        cmd.point_num = pn_reg;
        cmd.last      = (pn_reg == PN_LAST);
        unique case (state_reg)
            csp_pkg::ST_IDLE:    cmd.bad_clr = go;
            csp_pkg::ST_LD_ACC:  cmd.acc_load = 1'b1;
            csp_pkg::ST_MAC_MUL: cmd.mul_en = 1'b1;
            csp_pkg::ST_MAC_ACC: cmd.acc_upd = 1'b1;
            csp_pkg::ST_DCHK: begin
                if (ph_reg == csp_pkg::PH_DIAG) begin
                    cmd.bad_set    = stat.acc_le_zero;
                    cmd.sqrt_start = !stat.acc_le_zero;
                end
            end
            csp_pkg::ST_ZERO: cmd.fw_en = 1'b1;
            csp_pkg::ST_SQRT: begin
                cmd.fw_en  = stat.sqrt_done;
                cmd.fw_sel = csp_pkg::FW_ROOT;
            end
            csp_pkg::ST_DIV_GO: cmd.div_start = 1'b1;
            csp_pkg::ST_DIV: begin
                cmd.fw_en  = stat.div_done;
                cmd.fw_sel = csp_pkg::FW_QUOT;
            end
            csp_pkg::ST_COORD: cmd.coord_wr = 1'b1;
            csp_pkg::ST_OUT:   cmd.out_load = stat.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= csp_pkg::ST_IDLE;
            ph_reg    <= csp_pkg::PH_DIAG;
            ept_reg   <= csp_pkg::EP_MEAN;
            j_reg     <= '0;
            i_reg     <= '0;
            k_reg     <= '0;
            r_reg     <= '0;
            pi_reg    <= '0;
            pj_reg    <= '0;
            pk_reg    <= '0;
            ak_reg    <= 1'b0;
            pn_reg    <= '0;
        end else begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            ept_reg   <= ept_next;
            j_reg     <= j_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            r_reg     <= r_next;
            pi_reg    <= pi_next;
            pj_reg    <= pj_next;
            pk_reg    <= pk_next;
            ak_reg    <= ak_next;
            pn_reg    <= pn_next;
        end
    end

    assign idle = (state_reg == csp_pkg::ST_IDLE);

endmodule
`default_nettype wire

/* hdl/csp_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csp_datapath
// Stores, multiply-accumulate, square root, divider and output register.
// ----------------------------------------------------------------------------
module csp_datapath #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 load_en,
    input  wire logic [1:0]           load_op,
    input  wire logic [2:0]           load_row,
    input  wire logic [2:0]           load_col,
    input  wire logic [31:0]          load_value,
    input  wire csp_pkg::cmd_t        cmd,
    output csp_pkg::stat_t            stat,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic [csp_pkg::PN_W-1:0]  out_point,
    output logic [31:0]               out_coord [csp_pkg::NUM_COORD],
    output logic                      out_last,
    output logic                      out_bad
);

    localparam int ROW_W = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int FI_W  = (DIM * DIM > 1) ? $clog2(DIM * DIM) : 1;
    localparam int MW    = csp_pkg::MUL_W;
    localparam int PW    = csp_pkg::PROD_W;
    localparam int AW    = csp_pkg::ACC_W;
    localparam logic [63:0] BETA_RAW =
        csp_pkg::isqrt_const(64'(DIM + 2) << (2 * FRAC_BITS));
    localparam logic [63:0] HALF_RAW =
        csp_pkg::isqrt_const(64'(DIM + 2) << (2 * FRAC_BITS - 1));
    localparam logic signed [MW-1:0] BETA_FX = MW'(BETA_RAW);
    localparam logic signed [MW-1:0] HALF_FX = MW'(HALF_RAW);
    localparam logic [PW-1:0] FRAC_MASK = (PW'(1) << FRAC_BITS) - PW'(1);

    logic [31:0] mean_mem [DIM];
    logic [31:0] cov_mem  [DIM * DIM];
    logic [31:0] fac_mem  [DIM * DIM];

    logic [31:0]            mean_rd_reg, cov_rd_reg, fa_rd_reg, fb_rd_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [AW-1:0]   acc_reg;
    logic [31:0]            root_reg;
    logic                   div_neg_reg;
    logic                   bad_reg;
    logic [31:0]            coord_reg [csp_pkg::NUM_COORD];
    logic                   valid_reg;

    logic signed [MW-1:0]   fa_m, fb_m, ya, yb, mx, my;
    logic signed [PW-1:0]   biased, shifted;
    logic signed [AW-1:0]   prod_t;
    logic [63:0]            sq_rad;
    logic                   sq_done;
    logic [31:0]            sq_root;
    logic [31:0]            num32, num_mag;
    logic [63:0]            dv_dividend;
    logic                   dv_done;
    logic [63:0]            dv_quot;
    logic [31:0]            quot32;
    logic [31:0]            fw_data;

    // load path
    always_ff @(posedge aclk) begin
        if (load_en && load_op == csp_pkg::OP_LOAD_MEAN && 32'(load_row) < DIM) begin
            mean_mem[load_row[ROW_W-1:0]] <= load_value;
        end
        if (load_en && load_op == csp_pkg::OP_LOAD_COV && 32'(load_row) < DIM
            && load_col <= load_row) begin
            cov_mem[FI_W'(load_row * DIM + load_col)] <= load_value;
        end
        if (cmd.fw_en) begin
            fac_mem[cmd.fw_addr[FI_W-1:0]] <= fw_data;
        end
        mean_rd_reg <= mean_mem[cmd.mean_addr[ROW_W-1:0]];
        cov_rd_reg  <= cov_mem[cmd.cov_addr[FI_W-1:0]];
        fa_rd_reg   <= fac_mem[cmd.fa_addr[FI_W-1:0]];
        fb_rd_reg   <= fac_mem[cmd.fb_addr[FI_W-1:0]];
    end

    // multiplier operands
    always_comb begin
        fa_m = cmd.mask_a ? '0 : MW'($signed(fa_rd_reg));
        fb_m = cmd.mask_b ? '0 : MW'($signed(fb_rd_reg));
        ya   = cmd.neg_a ? -fa_m : fa_m;
        yb   = cmd.use_b ? (cmd.neg_b ? -fb_m : fb_m) : '0;
        if (cmd.emit_mode) begin
            case (cmd.mult_sel)
                csp_pkg::MS_HALF: mx = HALF_FX;
                csp_pkg::MS_BETA: mx = BETA_FX;
                default:          mx = '0;
            endcase
            my = ya + yb;
        end else begin
            mx = fa_m;
            my = fb_m;
        end
    end

    // product scaled down, truncated toward zero
    always_comb begin
        biased  = prod_reg + (prod_reg[PW-1] ? $signed(FRAC_MASK) : $signed(PW'(0)));
        shifted = biased >>> FRAC_BITS;
        prod_t  = shifted[AW-1:0];
    end

    // square root and divider operands, quotient saturation and factor write data
    always_comb begin
        if (acc_reg > 64'sh0000_0000_7FFF_FFFF) begin
            sq_rad = 64'h0000_0000_7FFF_FFFF << FRAC_BITS;
        end else begin
            sq_rad = 64'(acc_reg[30:0]) << FRAC_BITS;
        end
        num32       = csp_pkg::sat32(acc_reg);
        num_mag     = num32[31] ? (~num32 + 32'd1) : num32;
        dv_dividend = 64'(num_mag) << FRAC_BITS;
        if (!div_neg_reg) begin
            quot32 = (dv_quot > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : dv_quot[31:0];
        end else begin
            quot32 = (dv_quot > 64'h0000_0000_8000_0000) ? 32'h8000_0000
                   : (~dv_quot[31:0] + 32'd1);
        end
        case (cmd.fw_sel)
            csp_pkg::FW_ROOT: fw_data = sq_root;
            csp_pkg::FW_QUOT: fw_data = quot32;
            default:          fw_data = '0;
        endcase
    end

    csp_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.sqrt_start),
        .rad     (sq_rad),
        .done    (sq_done),
        .root    (sq_root)
    );

    csp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dv_dividend),
        .divisor  (root_reg),
        .done     (dv_done),
        .quot     (dv_quot)
    );

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= mx * my;
        end
        if (cmd.acc_load) begin
            acc_reg <= cmd.acc_from_mean ? AW'($signed(mean_rd_reg))
                                         : AW'($signed(cov_rd_reg));
        end else if (cmd.acc_upd) begin
            acc_reg <= cmd.emit_mode ? (acc_reg + prod_t) : (acc_reg - prod_t);
        end
        if (cmd.fw_en && cmd.fw_sel == csp_pkg::FW_ROOT) begin
            root_reg <= sq_root;
        end
        if (cmd.div_start) begin
            div_neg_reg <= num32[31];
        end
        if (cmd.coord_wr) begin
            coord_reg[cmd.coord_idx] <= csp_pkg::sat32(acc_reg);
        end
        if (cmd.out_load) begin
            out_point <= cmd.point_num;
            out_last  <= cmd.last;
            out_bad   <= bad_reg;
            for (int c = 0; c < csp_pkg::NUM_COORD; c++) begin
                out_coord[c] <= (c < DIM) ? coord_reg[c] : 32'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bad_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (cmd.bad_clr) begin
                bad_reg <= 1'b0;
            end else if (cmd.bad_set) begin
                bad_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign stat.acc_le_zero = acc_reg[AW-1] || (acc_reg == '0);
    assign stat.sqrt_done   = sq_done;
    assign stat.div_done    = dv_done;
    assign stat.out_free    = !valid_reg || out_ready;
    assign out_valid        = valid_reg;

endmodule
`default_nettype wire
